/* hdl/cramer3_pkg.sv */
// Shared widths, constants and helper types for the 3x3 linear solver.
// No dependencies; imported by every module in the solver.
`timescale 1ns / 1ps
package cramer3_pkg;
    localparam int COEF_W  = 16;
    localparam int COF_W   = 33;
    localparam int DET_W   = 49;
    localparam int NUM_W   = 51;
    localparam int SOL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int DIV_N_W = NUM_W + FRAC_W;
    localparam int DIV_D_W = DET_W;
    localparam int Q_W     = DIV_N_W;
    localparam logic [Q_W-1:0] POS_MAX = Q_W'(64'h7FFF_FFFF);
    localparam logic [Q_W-1:0] NEG_MAX = Q_W'(64'h8000_0000);

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       singular;
    } t_div_tag;
endpackage

/* hdl/cramer3_cofactor.sv */
// Multiply stages: cofactors, then determinant and adj(A)*b numerators.
// Depends on cramer3_pkg.
`timescale 1ns / 1ps
module cramer3_cofactor
    import cramer3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [COEF_W-1:0] i_a [9],
    input  logic signed [COEF_W-1:0] i_b [3],
    output logic                     o_valid,
    output logic signed [DET_W-1:0]  o_det,
    output logic signed [NUM_W-1:0]  o_num [3]
);
    logic                     r_v1, r_v2, r_v3;
    logic signed [COEF_W-1:0] r_a1 [3];
    logic signed [COEF_W-1:0] r_b1 [3];
    logic signed [31:0]       r_p1 [18];
    logic signed [COF_W-1:0]  r_c2 [9];
    logic signed [COEF_W-1:0] r_a2 [3];
    logic signed [COEF_W-1:0] r_b2 [3];
    logic signed [DET_W-1:0]  r_t3 [12];
    logic signed [DET_W-1:0]  r_det;
    logic signed [NUM_W-1:0]  r_num [3];
    logic signed [31:0]       n_p1 [18];

    // Products for the nine cofactors in cyclic-index form.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p1[(i*3+j)*2]   = i_a[((i+1)%3)*3+(j+1)%3] * i_a[((i+2)%3)*3+(j+2)%3];
                n_p1[(i*3+j)*2+1] = i_a[((i+1)%3)*3+(j+2)%3] * i_a[((i+2)%3)*3+(j+1)%3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1 products, stage 2 cofactors, stage 3 products, stage 4 sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= n_p1;
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= i_a[k];
                r_b1[k] <= i_b[k];
            end
            for (int k = 0; k < 9; k++) begin
                r_c2[k] <= COF_W'(r_p1[2*k]) - COF_W'(r_p1[2*k+1]);
            end
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            for (int k = 0; k < 3; k++) begin
                r_t3[k] <= DET_W'(r_a2[k]) * DET_W'(r_c2[k]);
                for (int j = 0; j < 3; j++) begin
                    r_t3[3+k*3+j] <= DET_W'(r_c2[j*3+k]) * DET_W'(r_b2[j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= r_t3[0] + r_t3[1] + r_t3[2];
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= NUM_W'(r_t3[3+k*3]) + NUM_W'(r_t3[4+k*3]) + NUM_W'(r_t3[5+k*3]);
            end
        end
    end

    assign o_det = r_det;
    assign o_num = r_num;
endmodule

/* hdl/cramer3_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on cramer3_pkg.
`timescale 1ns / 1ps
module cramer3_divider
    import cramer3_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_div_tag                i_tag,
    input  logic [DIV_N_W-1:0]      i_num,
    input  logic [DIV_D_W-1:0]      i_den,
    output t_div_tag                o_tag,
    output logic signed [SOL_W-1:0] o_quo
);
    localparam int R_W = DIV_D_W + 1;

    t_div_tag           r_tag [DIV_N_W+1];
    logic [DIV_N_W-1:0] r_n   [DIV_N_W+1];
    logic [R_W-1:0]     r_r   [DIV_N_W+1];
    logic [DIV_D_W-1:0] r_d   [DIV_N_W+1];
    logic [R_W-1:0]     n_rem;
    logic [Q_W-1:0]     n_q;

    // Stage zero holds the operands; each later stage settles one bit.
    // Only the valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        logic [R_W-1:0] t;
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_N_W; s++) r_tag[s].valid <= 1'b0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_n[0] <= i_num;
            r_r[0] <= '0;
            r_d[0] <= i_den;
            for (int s = 1; s <= DIV_N_W; s++) begin
                t = {r_r[s-1][R_W-2:0], r_n[s-1][DIV_N_W-1]};
                r_tag[s] <= r_tag[s-1];
                r_d[s] <= r_d[s-1];
                if (t >= {1'b0, r_d[s-1]}) begin
                    r_r[s] <= t - {1'b0, r_d[s-1]};
                    r_n[s] <= {r_n[s-1][DIV_N_W-2:0], 1'b1};
                end else begin
                    r_r[s] <= t;
                    r_n[s] <= {r_n[s-1][DIV_N_W-2:0], 1'b0};
                end
            end
        end
    end

    // Quotient bits have shifted fully into the numerator register.
    assign n_q   = r_n[DIV_N_W];
    assign n_rem = r_r[DIV_N_W];
    assign o_tag = r_tag[DIV_N_W];

    always_comb begin
        if (r_tag[DIV_N_W].singular) begin
            o_quo = '0;
        end else if (r_tag[DIV_N_W].neg) begin
            o_quo = (n_q > NEG_MAX) ? SOL_W'(NEG_MAX) : SOL_W'(-n_q);
        end else begin
            o_quo = (n_q > POS_MAX) ? SOL_W'(POS_MAX) : SOL_W'(n_q);
        end
    end
endmodule

/* hdl/solve_linear_system_3x3_core.sv */
// Top level of the pipelined 3x3 Cramer's-rule solver.
// Depends on cramer3_pkg, cramer3_cofactor and cramer3_divider.
// Accepts one system per cycle while o_ready is high; the pipe has 4 multiply stages,
// 1 sign stage, 68 divider stages and an output register. Rate is set by the fully
// pipelined multiply tree and the one-bit-per-stage divider; the whole pipe
// advances only when the output register is free or being emptied, so nothing
// is lost on a stall. Singular systems give zero solutions with the flag set.
`timescale 1ns / 1ps
module solve_linear_system_3x3_core
    import cramer3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COEF_W-1:0] i_a11, i_a12, i_a13,
    input  logic signed [COEF_W-1:0] i_a21, i_a22, i_a23,
    input  logic signed [COEF_W-1:0] i_a31, i_a32, i_a33,
    input  logic signed [COEF_W-1:0] i_b1, i_b2, i_b3,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SOL_W-1:0]  o_x_value,
    output logic signed [SOL_W-1:0]  o_y_value,
    output logic signed [SOL_W-1:0]  o_z_value,
    output logic signed [DET_W-1:0]  o_determinant,
    output logic                     o_singular
);
    logic                     w_en;
    logic signed [COEF_W-1:0] w_a [9];
    logic signed [COEF_W-1:0] w_b [3];
    logic                     w_cv;
    logic signed [DET_W-1:0]  w_det;
    logic signed [NUM_W-1:0]  w_num [3];
    t_div_tag                 r_tag [3];
    logic [DIV_N_W-1:0]       r_mn [3];
    logic [DIV_D_W-1:0]       r_md;
    logic signed [DET_W-1:0]  r_det_s [DIV_N_W+2];
    t_div_tag                 w_otag [3];
    logic signed [SOL_W-1:0]  w_quo [3];

    // Pipe moves when the output slot is empty or its transaction completes.
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_a = '{i_a11, i_a12, i_a13, i_a21, i_a22, i_a23, i_a31, i_a32, i_a33};
    assign w_b = '{i_b1, i_b2, i_b3};

    cramer3_cofactor u_cof (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_valid && w_en),
        .i_a(w_a), .i_b(w_b), .o_valid(w_cv), .o_det(w_det), .o_num(w_num)
    );

    // Sign and magnitude stage in front of the dividers; reset clears the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_tag[k].valid <= 1'b0;
        end else if (w_en) begin
            r_md <= w_det[DET_W-1] ? DIV_D_W'(-w_det) : DIV_D_W'(w_det);
            for (int k = 0; k < 3; k++) begin
                r_tag[k].valid    <= w_cv;
                r_tag[k].neg      <= w_num[k][NUM_W-1] ^ w_det[DET_W-1];
                r_tag[k].singular <= (w_det == '0);
                r_mn[k] <= {(w_num[k][NUM_W-1] ? NUM_W'(-w_num[k]) : NUM_W'(w_num[k])),
                            {FRAC_W{1'b0}}};
            end
            r_det_s[0] <= w_det;
            for (int s = 1; s < DIV_N_W + 2; s++) r_det_s[s] <= r_det_s[s-1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        cramer3_divider u_div (
            .i_clk, .i_rst_n, .i_en(w_en), .i_tag(r_tag[k]), .i_num(r_mn[k]),
            .i_den(r_md), .o_tag(w_otag[k]), .o_quo(w_quo[k])
        );
    end

    // Output register holds the result until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_otag[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_x_value     <= w_quo[0];
            o_y_value     <= w_quo[1];
            o_z_value     <= w_quo[2];
            o_determinant <= r_det_s[DIV_N_W+1];
            o_singular    <= w_otag[0].singular;
        end
    end

`ifndef ASSERT_OFF
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_otag[0].valid == w_otag[1].valid && w_otag[1].valid == w_otag[2].valid)
        else $error("divider lanes out of step");
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_x_value == '0 && o_determinant == '0)
        else $error("singular result not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_value))
        else $error("stalled result changed");
`endif
endmodule
